### sv/crc8pf_pkg.sv
// Package: payload types, control structs, status codes and the CRC-8 byte function.
package crc8pf_pkg;

    localparam logic [7:0]  CRC_INIT    = 8'hFF;
    localparam logic [7:0]  CRC_POLY    = 8'h31;
    localparam logic [3:0]  FRAME_LAST  = 4'd8;
    localparam logic [15:0] SCALE_RESET = 16'd6000;

    localparam logic [1:0] STATUS_OK      = 2'd0;
    localparam logic [1:0] STATUS_CRC_ERR = 2'd1;
    localparam logic [1:0] STATUS_BUS_ERR = 2'd2;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       frame_start;
        logic       bus_error;
    } in_word_t;

    typedef struct packed {
        logic [1:0]          status;
        logic signed [15:0]  raw_counts;
        logic signed [31:0]  pressure_hpa_q16;
    } out_word_t;

    typedef enum logic [0:0] {
        ST_IDLE,
        ST_DIV
    } state_t;

    typedef struct packed {
        logic take_byte;
        logic div_run;
    } cmd_t;

    typedef struct packed {
        logic start_div;
        logic div_last;
        logic out_free;
    } sts_t;

    // one byte through the MSB-first CRC-8 register
    function automatic logic [7:0] crc_byte(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int k = 0; k < 8; k++) begin
            if (c[7]) begin
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[6:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

### sv/crc8pf_ctrl.sv
// Controller: byte acceptance and division sequencing.
module crc8pf_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  crc8pf_pkg::sts_t     sts,
    output crc8pf_pkg::cmd_t     cmd
);

    crc8pf_pkg::state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= crc8pf_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            crc8pf_pkg::ST_IDLE: begin
                if (s_valid && s_ready && sts.start_div) begin
                    state_next = crc8pf_pkg::ST_DIV;
                end
            end
            crc8pf_pkg::ST_DIV: begin
                if (sts.div_last) begin
                    state_next = crc8pf_pkg::ST_IDLE;
                end
            end
            default: state_next = crc8pf_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        s_ready       = 1'b0;
        cmd.take_byte = 1'b0;
        cmd.div_run   = 1'b0;
        case (state_reg)
            crc8pf_pkg::ST_IDLE: begin
                s_ready       = sts.out_free;
                cmd.take_byte = s_valid && sts.out_free;
            end
            crc8pf_pkg::ST_DIV: begin
                cmd.div_run = 1'b1;
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

endmodule

### sv/crc8pf_dp.sv
// Datapath: frame state, CRC check, restoring divider and output register.
module crc8pf_dp #(
    parameter int FRAC_BITS = 16
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [15:0]           cfg_wr_data,
    input  crc8pf_pkg::in_word_t  s_word,
    input  crc8pf_pkg::cmd_t      cmd,
    output crc8pf_pkg::sts_t      sts,
    output logic                  m_valid,
    input  logic                  m_ready,
    output crc8pf_pkg::out_word_t m_word
);

    localparam int DW    = 16 + FRAC_BITS;
    localparam int CNT_W = $clog2(DW);

    logic [15:0] scale_reg;
    logic [3:0]  pos_reg, pos_next;
    logic [7:0]  crc_reg, crc_next;
    logic        good_reg, good_next;
    logic [15:0] word_reg, word_next;

    logic [DW-1:0]    q_reg, q_next;
    logic [15:0]      rem_reg, rem_next;
    logic [15:0]      div_reg, div_next;
    logic             neg_reg, neg_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    logic                  m_valid_reg, m_valid_next;
    crc8pf_pkg::out_word_t m_word_reg, m_word_next;

    logic        eff_clear;
    logic [3:0]  pos_eff;
    logic [7:0]  crc_eff;
    logic        good_eff;
    logic        good_new;
    logic        is_check;
    logic        last_byte;
    logic        load_imm;
    logic        load_div;
    logic [15:0] mag;
    logic [16:0] trial;
    logic        trial_ok;

    // final quotient including the bit resolved in the last step
    function automatic logic [31:0] q_next_ext(input logic [DW-1:0] q, input logic bit_in);
        logic [DW-1:0] qn;
        qn = {q[DW-2:0], bit_in};
        return 32'(qn);
    endfunction

    // frame_start or an impossible position restarts the frame before the byte
    always_comb begin
        eff_clear = s_word.frame_start || (pos_reg > crc8pf_pkg::FRAME_LAST);
        pos_eff   = eff_clear ? 4'd0 : pos_reg;
        crc_eff   = eff_clear ? crc8pf_pkg::CRC_INIT : crc_reg;
        good_eff  = eff_clear ? 1'b1 : good_reg;
        is_check  = pos_eff inside {4'd2, 4'd5, 4'd8};
        good_new  = is_check ? (good_eff && (crc_eff == s_word.data_byte)) : good_eff;
        last_byte = pos_eff == crc8pf_pkg::FRAME_LAST;
        load_imm  = cmd.take_byte && (s_word.bus_error || (last_byte && !good_new));
        load_div  = cmd.div_run && sts.div_last;
        mag       = word_reg[15] ? (16'd0 - word_reg) : word_reg;
        trial     = {rem_reg, q_reg[DW-1]} - {1'b0, div_reg};
        trial_ok  = !trial[16];
    end

    assign sts.start_div = !s_word.bus_error && last_byte && good_new;
    assign sts.div_last  = cnt_reg == CNT_W'(DW - 1);
    assign sts.out_free  = !m_valid_reg || m_ready;

    // frame state
    always_comb begin
        pos_next  = pos_reg;
        crc_next  = crc_reg;
        good_next = good_reg;
        word_next = word_reg;
        if (cmd.take_byte) begin
            if (s_word.bus_error) begin
                pos_next  = 4'd0;
                crc_next  = crc8pf_pkg::CRC_INIT;
                good_next = 1'b1;
            end else begin
                if (pos_eff == 4'd0) begin
                    word_next = {s_word.data_byte, 8'h00};
                end else if (pos_eff == 4'd1) begin
                    word_next = {word_reg[15:8], s_word.data_byte};
                end
                crc_next = is_check ? crc8pf_pkg::CRC_INIT
                                    : crc8pf_pkg::crc_byte(crc_eff, s_word.data_byte);
                if (last_byte) begin
                    pos_next  = 4'd0;
                    crc_next  = crc8pf_pkg::CRC_INIT;
                    good_next = 1'b1;
                end else begin
                    pos_next  = pos_eff + 4'd1;
                    good_next = good_new;
                end
            end
        end
    end

    // restoring divider, one quotient bit per cycle; q_reg holds dividend then quotient
    always_comb begin
        q_next   = q_reg;
        rem_next = rem_reg;
        div_next = div_reg;
        neg_next = neg_reg;
        cnt_next = cnt_reg;
        if (cmd.take_byte && sts.start_div) begin
            q_next   = DW'({mag, {FRAC_BITS{1'b0}}});
            rem_next = 16'd0;
            div_next = (scale_reg == 16'd0) ? 16'd1 : scale_reg;
            neg_next = word_reg[15];
            cnt_next = '0;
        end else if (cmd.div_run) begin
            q_next   = {q_reg[DW-2:0], trial_ok};
            rem_next = trial_ok ? trial[15:0] : {rem_reg[14:0], q_reg[DW-1]};
            cnt_next = cnt_reg + CNT_W'(1);
        end
    end

    // output register
    always_comb begin
        m_valid_next = m_valid_reg;
        m_word_next  = m_word_reg;
        if (m_ready) begin
            m_valid_next = 1'b0;
        end
        if (load_imm) begin
            m_valid_next                 = 1'b1;
            m_word_next.status           = s_word.bus_error ? crc8pf_pkg::STATUS_BUS_ERR
                                                            : crc8pf_pkg::STATUS_CRC_ERR;
            m_word_next.raw_counts       = '0;
            m_word_next.pressure_hpa_q16 = '0;
        end else if (load_div) begin
            m_valid_next                 = 1'b1;
            m_word_next.status           = crc8pf_pkg::STATUS_OK;
            m_word_next.raw_counts       = word_reg;
            m_word_next.pressure_hpa_q16 = neg_reg ? (32'd0 - q_next_ext(q_reg, trial_ok))
                                                   : q_next_ext(q_reg, trial_ok);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scale_reg   <= crc8pf_pkg::SCALE_RESET;
            pos_reg     <= 4'd0;
            crc_reg     <= crc8pf_pkg::CRC_INIT;
            good_reg    <= 1'b1;
            word_reg    <= 16'd0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                scale_reg <= cfg_wr_data;
            end
            pos_reg     <= pos_next;
            crc_reg     <= crc_next;
            good_reg    <= good_next;
            word_reg    <= word_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        q_reg      <= q_next;
        rem_reg    <= rem_next;
        div_reg    <= div_next;
        neg_reg    <= neg_next;
        cnt_reg    <= cnt_next;
        m_word_reg <= m_word_next;
    end

    assign m_valid = m_valid_reg;
    assign m_word  = m_word_reg;

`ifndef SYNTHESIS
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.take_byte |-> (!m_valid_reg || m_ready))
        else $error("byte taken while a result would be overwritten");

    a_pos_range: assert property (@(posedge aclk) disable iff (!aresetn)
        pos_reg <= crc8pf_pkg::FRAME_LAST)
        else $error("byte position beyond frame");

    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_word_reg.status != crc8pf_pkg::STATUS_OK) |->
        (m_word_reg.raw_counts == 16'sd0 && m_word_reg.pressure_hpa_q16 == 32'sd0))
        else $error("error word carries nonzero payload");

    a_quot_sign: assert property (@(posedge aclk) disable iff (!aresetn)
        load_div |=> (m_word_reg.status == crc8pf_pkg::STATUS_OK &&
        (m_word_reg.pressure_hpa_q16 == 32'sd0 ||
         m_word_reg.pressure_hpa_q16[31] == m_word_reg.raw_counts[15])))
        else $error("quotient sign disagrees with raw pressure");
`endif

endmodule

### sv/crc8_checked_pressure_frame.sv
// Top level: CRC-8 checked pressure frame decoder with Q16.16 scaling.
//
//  port group      dir  handshake          payload
//  s_*  (bytes)    in   s_valid/s_ready    in_word_t  {data_byte, frame_start, bus_error}
//  m_*  (results)  out  m_valid/m_ready    out_word_t {status, raw_counts, pressure_hpa_q16}
//  cfg_*           in   cfg_wr_en          scale_counts_per_hpa
//
// The ninth byte of a good frame starts the restoring divider, which resolves
// 16 + FRAC_BITS quotient bits, one at a time; no byte is taken while it runs.
// Bus errors and CRC failures give their word in the cycle after the byte.
// Reset is synchronous; the scale register comes up at 6000.
// Bytes are taken only while the result register is empty or being drained.
module crc8_checked_pressure_frame #(
    parameter int FRAC_BITS = 16
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [15:0]           cfg_wr_data,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  crc8pf_pkg::in_word_t  s_word,
    output logic                  m_valid,
    input  logic                  m_ready,
    output crc8pf_pkg::out_word_t m_word
);

    crc8pf_pkg::cmd_t cmd;
    crc8pf_pkg::sts_t sts;

    crc8pf_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    crc8pf_dp #(
        .FRAC_BITS (FRAC_BITS)
    ) u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_word      (s_word),
        .cmd         (cmd),
        .sts         (sts),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_word      (m_word)
    );

endmodule

### sim/testbench.sv
// Testbench for the CRC-8 checked pressure frame decoder: directed table, then random frames.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int Q_FRAC         = 16;
    localparam int DRAIN_CYCLES   = 48;      // wait after the queue empties: a divider run plus margin
    localparam int CYCLE_LIMIT    = 600000;
    localparam int PHASES         = 7;
    localparam int RAND_PER_PHASE = 250;
    localparam int MAX_LOGGED     = 30;

    // how a directed row fills its data byte
    typedef enum logic [1:0] {
        CHK_NONE,
        CHK_GOOD,
        CHK_BAD
    } crc_fill_t;

    typedef struct {
        logic [7:0] data;
        logic       fs;
        logic       be;
        crc_fill_t  fill;
        logic       typed;
        logic [1:0] status;
    } dir_row_t;

    localparam int DIR_ROWS = 22;

    dir_row_t dir_rows [DIR_ROWS] = '{
        // first frame after reset, no frame_start, raw 0x7FFF, all CRCs good
        '{8'h7F, 1'b0, 1'b0, CHK_NONE, 1'b0, crc8pf_pkg::STATUS_OK},
        '{8'hFF, 1'b0, 1'b0, CHK_NONE, 1'b0, crc8pf_pkg::STATUS_OK},
        '{8'h00, 1'b0, 1'b0, CHK_GOOD, 1'b0, crc8pf_pkg::STATUS_OK},
        '{8'h00, 1'b0, 1'b0, CHK_NONE, 1'b0, crc8pf_pkg::STATUS_OK},
        '{8'h00, 1'b0, 1'b0, CHK_NONE, 1'b0, crc8pf_pkg::STATUS_OK},
        '{8'h00, 1'b0, 1'b0, CHK_GOOD, 1'b0, crc8pf_pkg::STATUS_OK},
        '{8'hFF, 1'b0, 1'b0, CHK_NONE, 1'b0, crc8pf_pkg::STATUS_OK},
        '{8'hFF, 1'b0, 1'b0, CHK_NONE, 1'b0, crc8pf_pkg::STATUS_OK},
        '{8'h00, 1'b0, 1'b0, CHK_GOOD, 1'b0, crc8pf_pkg::STATUS_OK},
        // bus error two bytes in, frame_start set too: bus error wins
        '{8'hAA, 1'b0, 1'b0, CHK_NONE, 1'b0, crc8pf_pkg::STATUS_OK},
        '{8'h55, 1'b0, 1'b0, CHK_NONE, 1'b0, crc8pf_pkg::STATUS_OK},
        '{8'h3C, 1'b1, 1'b1, CHK_NONE, 1'b1, crc8pf_pkg::STATUS_BUS_ERR},
        // stray byte, resync on frame_start, raw 0x8000, middle CRC broken
        '{8'h01, 1'b0, 1'b0, CHK_NONE, 1'b0, crc8pf_pkg::STATUS_OK},
        '{8'h80, 1'b1, 1'b0, CHK_NONE, 1'b0, crc8pf_pkg::STATUS_OK},
        '{8'h00, 1'b0, 1'b0, CHK_NONE, 1'b0, crc8pf_pkg::STATUS_OK},
        '{8'h00, 1'b0, 1'b0, CHK_GOOD, 1'b0, crc8pf_pkg::STATUS_OK},
        '{8'hFF, 1'b0, 1'b0, CHK_NONE, 1'b0, crc8pf_pkg::STATUS_OK},
        '{8'hFF, 1'b0, 1'b0, CHK_NONE, 1'b0, crc8pf_pkg::STATUS_OK},
        '{8'h00, 1'b0, 1'b0, CHK_BAD,  1'b0, crc8pf_pkg::STATUS_OK},
        '{8'h12, 1'b0, 1'b0, CHK_NONE, 1'b0, crc8pf_pkg::STATUS_OK},
        '{8'h34, 1'b0, 1'b0, CHK_NONE, 1'b0, crc8pf_pkg::STATUS_OK},
        '{8'h00, 1'b0, 1'b0, CHK_GOOD, 1'b1, crc8pf_pkg::STATUS_CRC_ERR}
    };

    logic [15:0] EXTREME_RAW [5] = '{16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF, 16'h0001};
    logic [15:0] phase_scale [PHASES] = '{16'd6000, 16'd1, 16'd65535, 16'd0, 16'd24000,
                                          16'd2, 16'd3};

    logic                  aclk;
    logic                  aresetn;
    logic                  cfg_wr_en;
    logic [15:0]           cfg_wr_data;
    logic                  s_valid;
    logic                  s_ready;
    crc8pf_pkg::in_word_t  s_word;
    logic                  m_valid;
    logic                  m_ready;
    crc8pf_pkg::out_word_t m_word;

    // decoder state as predicted
    logic [3:0]  fr_pos    = 4'd0;
    logic [7:0]  fr_crc    = crc8pf_pkg::CRC_INIT;
    logic        fr_good   = 1'b1;
    logic [15:0] fr_word   = 16'd0;
    logic [15:0] scale_reg = crc8pf_pkg::SCALE_RESET;

    crc8pf_pkg::out_word_t pending_results [$];

    int  err_count   = 0;
    int  cycle_count = 0;
    int  bytes_sent  = 0;
    int  n_ok        = 0;
    int  n_crc       = 0;
    int  n_bus       = 0;
    int  rx_hold_req = 0;
    bit  tx_gaps_on  = 1'b1;
    bit  rx_gaps_on  = 1'b1;

    crc8_checked_pressure_frame #(
        .FRAC_BITS(Q_FRAC)
    ) u_top (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_word     (s_word),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_word     (m_word)
    );

    always begin
        aclk = 1'b0;
        #4;
        aclk = 1'b1;
        #4;
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // bit-serial CRC-8, MSB first
    function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] r;
        logic       fb;
        r = crc;
        for (int i = 7; i >= 0; i--) begin
            fb = r[7] ^ b[i];
            r  = {r[6:0], 1'b0} ^ (fb ? crc8pf_pkg::CRC_POLY : 8'h00);
        end
        return r;
    endfunction

    function automatic logic signed [31:0] scaled_q16(input logic signed [15:0] raw,
                                                      input logic [15:0] scale);
        longint num;
        longint den;
        num = longint'(raw) * (longint'(1) << Q_FRAC);
        den = (scale == 16'd0) ? 64'sd1 : longint'(scale);
        return 32'(num / den);    // signed division truncates toward zero
    endfunction

    function automatic void clear_frame();
        fr_pos  = 4'd0;
        fr_crc  = crc8pf_pkg::CRC_INIT;
        fr_good = 1'b1;
    endfunction

    // advance the predicted decoder by one byte; returns 1 when a result word is due
    function automatic logic decode_byte(input crc8pf_pkg::in_word_t w,
                                         output crc8pf_pkg::out_word_t r);
        logic [3:0] pos;
        r = '0;
        if (w.bus_error) begin
            clear_frame();
            r.status = crc8pf_pkg::STATUS_BUS_ERR;
            return 1'b1;
        end
        if (w.frame_start || fr_pos > crc8pf_pkg::FRAME_LAST) begin
            clear_frame();
        end
        pos = fr_pos;
        if (pos == 4'd0) begin
            fr_word[15:8] = w.data_byte;
        end else if (pos == 4'd1) begin
            fr_word[7:0] = w.data_byte;
        end
        if ((pos % 3) == 2) begin
            if (fr_crc != w.data_byte) begin
                fr_good = 1'b0;
            end
            fr_crc = crc8pf_pkg::CRC_INIT;
        end else begin
            fr_crc = crc8_update(fr_crc, w.data_byte);
        end
        if (pos == crc8pf_pkg::FRAME_LAST) begin
            if (fr_good) begin
                r.status           = crc8pf_pkg::STATUS_OK;
                r.raw_counts       = fr_word;
                r.pressure_hpa_q16 = scaled_q16(fr_word, scale_reg);
            end else begin
                r.status = crc8pf_pkg::STATUS_CRC_ERR;
            end
            clear_frame();
            return 1'b1;
        end
        fr_pos = pos + 4'd1;
        return 1'b0;
    endfunction

    task automatic log_mismatch(input string msg);
        err_count++;
        if (err_count <= MAX_LOGGED) begin
            $display("MISMATCH @%0t: %s", $time, msg);
        end
    endtask

    task automatic send_byte(input crc8pf_pkg::in_word_t w, input logic typed,
                             input crc8pf_pkg::out_word_t typed_word);
        crc8pf_pkg::out_word_t r;
        int                    gap;
        if ($urandom_range(0, 31) == 0) begin
            tx_gaps_on = !tx_gaps_on;
        end
        gap = tx_gaps_on ? $urandom_range(0, 7) : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_word  <= w;
        do @(posedge aclk); while (!s_ready);
        bytes_sent++;
        if (decode_byte(w, r)) begin
            pending_results.push_back(typed ? typed_word : r);
        end
    endtask

    // mostly well-formed replies; some with a bus error, some cut short, some noise
    task automatic send_random_chunk();
        crc8pf_pkg::in_word_t burst [$];
        logic [7:0]           wb [6];
        logic [7:0]           c;
        int                   kind;
        int                   n;
        int                   cut;
        kind = $urandom_range(0, 99);
        if (kind >= 90) begin
            n = $urandom_range(1, 6);
            repeat (n) begin
                burst.push_back('{8'($urandom), $urandom_range(0, 3) == 0,
                                  $urandom_range(0, 15) == 0});
            end
        end else begin
            for (int i = 0; i < 6; i++) begin
                wb[i] = 8'($urandom);
            end
            if ($urandom_range(0, 4) == 0) begin
                {wb[0], wb[1]} = EXTREME_RAW[$urandom_range(0, 4)];
            end
            for (int i = 0; i < 3; i++) begin
                c = crc8_update(crc8_update(crc8pf_pkg::CRC_INIT, wb[2*i]), wb[2*i+1]);
                if ($urandom_range(0, 9) == 0) begin
                    c ^= 8'($urandom_range(1, 255));
                end
                burst.push_back('{wb[2*i], i == 0 && $urandom_range(0, 3) != 0, 1'b0});
                burst.push_back('{wb[2*i+1], 1'b0, 1'b0});
                burst.push_back('{c, 1'b0, 1'b0});
            end
            if (kind >= 80) begin
                cut = $urandom_range(1, 8);
                while (burst.size() > cut) burst.pop_back();
            end else if (kind >= 70) begin
                cut = $urandom_range(0, 8);
                burst[cut] = '{8'($urandom), 1'($urandom_range(0, 1)), 1'b1};
                while (burst.size() > cut + 1) burst.pop_back();
            end
        end
        foreach (burst[k]) begin
            send_byte(burst[k], 1'b0, '0);
        end
    endtask

    task automatic wait_drained();
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_scale(input logic [15:0] v);
        s_valid <= 1'b0;
        wait_drained();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        scale_reg = v;
    endtask

    // result sink: random stalls, plus a long hold-off on request
    initial begin : result_sink
        int gap;
        m_ready = 1'b0;
        wait (aresetn === 1'b1);
        @(posedge aclk);
        forever begin
            if (rx_hold_req > 0) begin
                m_ready <= 1'b0;
                repeat (rx_hold_req) @(posedge aclk);
                rx_hold_req = 0;
            end
            if ($urandom_range(0, 31) == 0) begin
                rx_gaps_on = !rx_gaps_on;
            end
            gap = rx_gaps_on ? $urandom_range(0, 7) : 0;
            if (gap > 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
        end
    end

    always @(posedge aclk) begin : result_check
        crc8pf_pkg::out_word_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                log_mismatch($sformatf("result word with nothing pending, status %0d",
                                       m_word.status));
            end else begin
                want = pending_results.pop_front();
                if (m_word.status !== want.status) begin
                    log_mismatch($sformatf("status %0d, want %0d",
                                           m_word.status, want.status));
                end
                if (m_word.raw_counts !== want.raw_counts) begin
                    log_mismatch($sformatf("raw_counts %0d, want %0d",
                                           m_word.raw_counts, want.raw_counts));
                end
                if (m_word.pressure_hpa_q16 !== want.pressure_hpa_q16) begin
                    log_mismatch($sformatf("pressure_hpa_q16 %0d, want %0d",
                                           m_word.pressure_hpa_q16, want.pressure_hpa_q16));
                end
                case (want.status)
                    crc8pf_pkg::STATUS_OK:      n_ok++;
                    crc8pf_pkg::STATUS_CRC_ERR: n_crc++;
                    default:                    n_bus++;
                endcase
            end
        end
    end

    initial begin : stimulus
        crc8pf_pkg::in_word_t  w;
        crc8pf_pkg::out_word_t typed_word;
        int                    target;
        aresetn     = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = 16'd0;
        s_valid     = 1'b0;
        s_word      = '0;
        phase_scale[5] = 16'($urandom_range(2, 65534));
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (dir_rows[i]) begin
            case (dir_rows[i].fill)
                CHK_GOOD: w.data_byte = fr_crc;
                CHK_BAD:  w.data_byte = ~fr_crc;
                default:  w.data_byte = dir_rows[i].data;
            endcase
            w.frame_start = dir_rows[i].fs;
            w.bus_error   = dir_rows[i].be;
            typed_word    = '{dir_rows[i].status, 16'sd0, 32'sd0};
            send_byte(w, dir_rows[i].typed, typed_word);
        end

        for (int ph = 0; ph < PHASES; ph++) begin
            if (ph > 0) begin
                write_scale(phase_scale[ph]);
            end
            // sink takes one word and then stalls long enough to back up the input
            rx_hold_req = $urandom_range(200, 400);
            target = bytes_sent + RAND_PER_PHASE;
            while (bytes_sent < target) send_random_chunk();
        end

        s_valid <= 1'b0;
        wait_drained();
        $display("Sent %0d bytes over %0d scale settings, including 1, 65535 and zero.",
                 bytes_sent, PHASES);
        $display("Checked %0d ok, %0d CRC-error and %0d bus-error results.",
                 n_ok, n_crc, n_bus);
        if (err_count == 0 && pending_results.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
